FILE: rtl/core/rad_pkg.sv
// Shared types and constants for the arithmetic unit with divide step.
// Holds the operation codes and field widths; depends on nothing else.
`default_nettype none

package rad_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned ImmW = 8;
  localparam int unsigned ActW = 4;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [ActW-1:0] {
    ACT_ADD   = 4'd0,
    ACT_ADDI  = 4'd1,
    ACT_ADDV  = 4'd2,
    ACT_ADDC  = 4'd3,
    ACT_SUB   = 4'd4,
    ACT_SUBC  = 4'd5,
    ACT_NEG   = 4'd6,
    ACT_NEGC  = 4'd7,
    ACT_DIV0U = 4'd8,
    ACT_DIV0S = 4'd9,
    ACT_DIV1  = 4'd10,
    ACT_LOAD  = 4'd11
  } action_e;

endpackage

`default_nettype wire

FILE: rtl/core/risc_alu_with_divide_step_core.sv
// Top level of the arithmetic unit: register file memory, execute stage and output register.
// Depends on rad_pkg for operation codes and widths.
`default_nettype none

// One instruction word enters per cycle and one result word leaves per cycle while the
// output side is not stalled. The edge that accepts an instruction word also reads Rn and Rm
// from the synchronous register file and loads the execute stage, where the result is worked
// out; an edge on which the output register is free then writes Rn back, updates T, Q and M
// and loads the output register, which offers the result word. A write in the execute stage
// is forwarded to a read issued in the same cycle, so dependent instructions follow without
// gaps. Registers read as zero until first written, tracked by one valid bit per register.
module risc_alu_with_divide_step_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // action[3:0], dest_index[7:4], src_index[11:8], imm_byte[19:12], load_value[51:20]
  input  wire logic [rad_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // dest_value[31:0], t_bit[32], q_bit[33], m_bit[34]
  output logic [rad_pkg::OutDataW-1:0]      m_axis_tdata
);
  import rad_pkg::*;

  logic [WordW-1:0]   mem_q [NumRegs];
  logic [NumRegs-1:0] vld_q;

  logic               in_acc;
  logic [ActW-1:0]    in_act;
  logic [RegIdxW-1:0] in_n;
  logic [RegIdxW-1:0] in_m;
  logic [ImmW-1:0]    in_imm;
  logic [WordW-1:0]   in_ldv;

  logic               s1_valid_q;
  logic [ActW-1:0]    s1_act_q;
  logic [RegIdxW-1:0] s1_n_q;
  logic [ImmW-1:0]    s1_imm_q;
  logic [WordW-1:0]   s1_ldv_q;
  logic [WordW-1:0]   rn_raw_q;
  logic [WordW-1:0]   rm_raw_q;
  logic               vld_n_q;
  logic               vld_m_q;
  logic               byp_n_q;
  logic               byp_m_q;
  logic [WordW-1:0]   byp_data_q;

  logic               t_q;
  logic               q_q;
  logic               m_q;
  logic               t_d;
  logic               q_d;
  logic               m_d;

  logic               out_valid_q;
  logic [WordW-1:0]   out_val_q;
  logic               out_t_q;
  logic               out_q_q;
  logic               out_m_q;

  logic               out_free;
  logic               s1_adv;
  logic [WordW-1:0]   rn;
  logic [WordW-1:0]   rm;
  logic [WordW-1:0]   op_a;
  logic [WordW-1:0]   op_b;
  logic               cin;
  logic [WordW:0]     sum;
  logic [WordW-1:0]   res;
  logic               same_qm;

  assign in_act = s_axis_tdata[3:0];
  assign in_n   = s_axis_tdata[7:4];
  assign in_m   = s_axis_tdata[11:8];
  assign in_imm = s_axis_tdata[19:12];
  assign in_ldv = s_axis_tdata[51:20];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_m_q, out_q_q, out_t_q, out_val_q};

  // Register file: one write port, two synchronous read ports.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[s1_n_q] <= res;
    end
    if (in_acc) begin
      rn_raw_q <= mem_q[in_n];
      rm_raw_q <= mem_q[in_m];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (s1_adv) begin
      vld_q[s1_n_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_act_q   <= in_act;
      s1_n_q     <= in_n;
      s1_imm_q   <= in_imm;
      s1_ldv_q   <= in_ldv;
      vld_n_q    <= vld_q[in_n];
      vld_m_q    <= vld_q[in_m];
      byp_n_q    <= s1_adv && (s1_n_q == in_n);
      byp_m_q    <= s1_adv && (s1_n_q == in_m);
      byp_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_comb begin
    rn = byp_n_q ? byp_data_q : (vld_n_q ? rn_raw_q : '0);
    rm = byp_m_q ? byp_data_q : (vld_m_q ? rm_raw_q : '0);
  end

  assign same_qm = (q_q == m_q);

  // Operand selection for the single shared adder.
  always_comb begin
    op_a = rn;
    op_b = rm;
    cin  = 1'b0;
    unique case (s1_act_q)
      ACT_ADDI: op_b = {{(WordW-ImmW){s1_imm_q[ImmW-1]}}, s1_imm_q};
      ACT_ADDC: cin = t_q;
      ACT_SUB: begin
        op_b = ~rm;
        cin  = 1'b1;
      end
      ACT_SUBC: begin
        op_b = ~rm;
        cin  = !t_q;
      end
      ACT_NEG: begin
        op_a = '0;
        op_b = ~rm;
        cin  = 1'b1;
      end
      ACT_NEGC: begin
        op_a = '0;
        op_b = ~rm;
        cin  = !t_q;
      end
      ACT_DIV1: begin
        op_a = {rn[WordW-2:0], t_q};
        op_b = same_qm ? ~rm : rm;
        cin  = same_qm;
      end
      default: begin
      end
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, op_b} + {{WordW{1'b0}}, cin};

  always_comb begin
    res = rn;
    t_d = t_q;
    q_d = q_q;
    m_d = m_q;
    unique case (s1_act_q)
      ACT_ADD, ACT_ADDI, ACT_SUB, ACT_NEG: res = sum[WordW-1:0];
      ACT_ADDV: begin
        res = sum[WordW-1:0];
        t_d = (rn[WordW-1] ^ sum[WordW-1]) & (rn[WordW-1] ~^ rm[WordW-1]);
      end
      ACT_ADDC: begin
        res = sum[WordW-1:0];
        t_d = sum[WordW];
      end
      ACT_SUBC, ACT_NEGC: begin
        res = sum[WordW-1:0];
        t_d = !sum[WordW];
      end
      ACT_DIV0U: begin
        t_d = 1'b0;
        q_d = 1'b0;
        m_d = 1'b0;
      end
      ACT_DIV0S: begin
        q_d = rn[WordW-1];
        m_d = rm[WordW-1];
        t_d = rn[WordW-1] ^ rm[WordW-1];
      end
      ACT_DIV1: begin
        res = sum[WordW-1:0];
        q_d = rn[WordW-1] ^ (same_qm ? !sum[WordW] : sum[WordW]) ^ m_q;
        t_d = (q_d == m_q);
      end
      ACT_LOAD: res = s1_ldv_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= 1'b0;
      q_q <= 1'b0;
      m_q <= 1'b0;
    end else if (s1_adv) begin
      t_q <= t_d;
      q_q <= q_d;
      m_q <= m_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_val_q <= res;
      out_t_q   <= t_d;
      out_q_q   <= q_d;
      out_m_q   <= m_d;
    end
  end

  // The input side never stalls while the output side is taking words.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output is draining");

  // A divide setup for unsigned operands leaves all three status bits clear.
  a_div0u_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_act_q == ACT_DIV0U) |=> (!out_t_q && !out_q_q && !out_m_q))
    else $error("div0u left a status bit set");

  // A load reports exactly the value it carried.
  a_load_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_act_q == ACT_LOAD) |=> (out_val_q == $past(s1_ldv_q)))
    else $error("load result differs from the loaded value");

endmodule

`default_nettype wire
